FILE: design/odfu_pkg.sv
// Shared widths, register indexes and pipeline types for the OBB detection filter.
`default_nettype none

package odfu_pkg;

    // Field widths
    localparam int COORD_W    = 20;
    localparam int CONF_W     = 17;
    localparam int CLASS_W    = 16;
    localparam int SLOT_W     = 3;
    localparam int INV_W      = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + INV_W + 1;
    localparam int FRAC_DROP  = 16;
    localparam int QUOT_W     = PROD_W - FRAC_DROP;
    localparam int SLOT_ID_W  = 16;
    localparam int MAX_SLOTS  = 4;
    localparam int SLOT_VEC_W = SLOT_ID_W * MAX_SLOTS;

    // Slot count default
    localparam int NUM_SLOTS_DEF = 4;

    // Stream widths
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (6 * COORD_W + CONF_W + CLASS_W + SLOT_W);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Numeric constants
    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(65536);
    localparam logic [INV_W-1:0]  INV_ONE  = INV_W'(65536);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [SLOT_W-1:0] LABEL_GENERIC = SLOT_W'(4);

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OFFSET_X        = 3'd0,
        REG_OFFSET_Y        = 3'd1,
        REG_INV_SCALE_X     = 3'd2,
        REG_INV_SCALE_Y     = 3'd3,
        REG_DEFAULT_THR     = 3'd4,
        REG_FILTER_COUNT    = 3'd5,
        REG_SLOT_CLASS_IDS  = 3'd6,
        REG_SLOT_THRESHOLDS = 3'd7
    } cfg_reg_t;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_ce_t;

    // Row attributes carried alongside the coordinates
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] cls;
        logic [CONF_W-1:0]  score;
    } meta_t;

    // One finished row, ready for the two output beats
    typedef struct packed {
        meta_t                     meta;
        logic [COORD_W-1:0]        max_y;
        logic [COORD_W-1:0]        min_y;
        logic [COORD_W-1:0]        max_x;
        logic [COORD_W-1:0]        min_x;
        logic [3:0][COORD_W-1:0]   cy;
        logic [3:0][COORD_W-1:0]   cx;
    } row_t;

endpackage

`default_nettype wire

FILE: design/odfu_map.sv
// Three-stage unmapping of one coordinate: subtract offset, scale, round and saturate.
`default_nettype none

module odfu_map (
    input  logic                                clk,
    input  odfu_pkg::stage_ce_t                 ce,
    input  logic signed [odfu_pkg::COORD_W-1:0] coord,
    input  logic signed [odfu_pkg::COORD_W-1:0] offset,
    input  logic        [odfu_pkg::INV_W-1:0]   inv_scale,
    output logic signed [odfu_pkg::COORD_W-1:0] mapped
);
    import odfu_pkg::*;

    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [INV_W:0]     inv_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [COORD_W-1:0] mapped_reg;
    logic signed [COORD_W-1:0] mapped_next;

    // Exact difference
    assign diff_next = DIFF_W'(coord) - DIFF_W'(offset);

    // Scale by the reciprocal, 16 fraction bits
    assign inv_s     = {1'b0, inv_scale};
    assign prod_next = PROD_W'(diff_reg) * PROD_W'(inv_s);

    // Round to nearest with ties up, then saturate
    assign rounded = prod_reg + ROUND_HALF;
    assign quot    = rounded[PROD_W-1:FRAC_DROP];

    always_comb
    begin
        if (quot > QUOT_W'(COORD_MAX))
        begin
            mapped_next = COORD_MAX;
        end
        else if (quot < QUOT_W'(COORD_MIN))
        begin
            mapped_next = COORD_MIN;
        end
        else
        begin
            mapped_next = quot[COORD_W-1:0];
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (ce.s1)
        begin
            diff_reg <= diff_next;
        end
        if (ce.s2)
        begin
            prod_reg <= prod_next;
        end
        if (ce.s3)
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped = mapped_reg;

endmodule

`default_nettype wire

FILE: design/odfu_bounds.sv
// Two-stage min/max reduction of four mapped coordinates on one axis.
`default_nettype none

module odfu_bounds (
    input  logic                                clk,
    input  odfu_pkg::stage_ce_t                 ce,
    input  logic signed [odfu_pkg::COORD_W-1:0] coord [4],
    output logic signed [odfu_pkg::COORD_W-1:0] coord_out [4],
    output logic signed [odfu_pkg::COORD_W-1:0] lo,
    output logic signed [odfu_pkg::COORD_W-1:0] hi,
    output logic                                extent_ok
);
    import odfu_pkg::*;

    logic signed [COORD_W-1:0] c4_reg [4];
    logic signed [COORD_W-1:0] c5_reg [4];
    logic signed [COORD_W-1:0] lo01_reg, hi01_reg, lo23_reg, hi23_reg;
    logic signed [COORD_W-1:0] lo01_next, hi01_next, lo23_next, hi23_next;
    logic signed [COORD_W-1:0] lo_reg, hi_reg, lo_next, hi_next;

    // Pairwise min and max
    assign lo01_next = (coord[1] < coord[0]) ? coord[1] : coord[0];
    assign hi01_next = (coord[1] > coord[0]) ? coord[1] : coord[0];
    assign lo23_next = (coord[3] < coord[2]) ? coord[3] : coord[2];
    assign hi23_next = (coord[3] > coord[2]) ? coord[3] : coord[2];

    // Final min and max, first pair wins ties
    assign lo_next = (lo23_reg < lo01_reg) ? lo23_reg : lo01_reg;
    assign hi_next = (hi23_reg > hi01_reg) ? hi23_reg : hi01_reg;

    // Positive extent on this axis
    assign extent_ok = hi_next > lo_next;

    always_ff @(posedge clk)
    begin
        if (ce.s4)
        begin
            lo01_reg <= lo01_next;
            hi01_reg <= hi01_next;
            lo23_reg <= lo23_next;
            hi23_reg <= hi23_next;
            c4_reg   <= coord;
        end
        if (ce.s5)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            c5_reg <= c4_reg;
        end
    end

    assign coord_out = c5_reg;
    assign lo        = lo_reg;
    assign hi        = hi_reg;

endmodule

`default_nettype wire

FILE: design/odfu_out.sv
// Output register that sends one finished row as two stream beats.
`default_nettype none

module odfu_out (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ld_valid,
    output logic                                 ld_ready,
    input  odfu_pkg::row_t                       row,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [odfu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import odfu_pkg::*;

    row_t row_reg;
    logic full_reg;
    logic full_next;
    logic beat_reg;
    logic beat_next;
    logic take;
    logic load;

    assign take     = full_reg && m_tready;
    assign ld_ready = !full_reg || (beat_reg && m_tready);
    assign load     = ld_valid && ld_ready;

    // Advance beat, refill on the last transfer
    always_comb
    begin
        full_next = full_reg;
        beat_next = beat_reg;
        if (load)
        begin
            full_next = 1'b1;
            beat_next = 1'b0;
        end
        else if (take)
        begin
            if (beat_reg)
            begin
                full_next = 1'b0;
                beat_next = 1'b0;
            end
            else
            begin
                beat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            beat_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row;
        end
    end

    // Pick the corner pair and bound for the current beat
    always_comb
    begin
        if (beat_reg)
        begin
            m_tdata = {OUT_PAD_W'(0), row_reg.meta.slot, row_reg.meta.cls, row_reg.meta.score,
                       row_reg.max_y, row_reg.max_x,
                       row_reg.cy[3], row_reg.cx[3], row_reg.cy[2], row_reg.cx[2]};
        end
        else
        begin
            m_tdata = {OUT_PAD_W'(0), row_reg.meta.slot, row_reg.meta.cls, row_reg.meta.score,
                       row_reg.min_y, row_reg.min_x,
                       row_reg.cy[1], row_reg.cx[1], row_reg.cy[0], row_reg.cx[0]};
        end
    end

    assign m_tvalid = full_reg;
    assign m_tlast  = beat_reg;

endmodule

`default_nettype wire

FILE: design/obb_detection_filter_unmap.sv
// Top level of the oriented-box detection filter with letterbox unmapping.
//
// Input stream s_*: one detection row per transfer (four corners, confidence,
// class). Output stream m_*: two transfers per kept row; tlast marks the
// second, which carries corners 2 and 3 and the maximum bounds, while the
// first carries corners 0 and 1 and the minimum bounds.
// Configuration: cfg_we with cfg_addr and cfg_data writes one register per
// clock; write only while no row is in flight.
// A row passes the pipeline stages and then the output register before
// its first beat shows on m_tvalid; the second beat follows once the
// first is taken. The output register loads the next kept row as the
// last beat of the current one is taken; a rejected row takes one pipeline slot and no output.
// The pipeline is five stages: filter and subtract, multiply, round and
// saturate, pairwise min/max, final min/max with extent check.
// Reset clears all valid bits and returns the configuration registers to
// their reset values. When the receiver stalls, the pipeline keeps filling
// its empty stages and then deasserts s_tready; nothing is lost or repeated.
`default_nettype none

module obb_detection_filter_unmap #(
    parameter int NUM_SLOTS = odfu_pkg::NUM_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, confidence, class number, zero pad
    input  logic [odfu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, bound_x, bound_y,
    // score, class_out, label_slot, zero pad
    output logic [odfu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [odfu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [odfu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import odfu_pkg::*;

    // Configuration registers
    logic signed [COORD_W-1:0] offset_x_reg, offset_y_reg;
    logic [INV_W-1:0]          inv_scale_x_reg, inv_scale_y_reg;
    logic [CONF_W-1:0]         default_thr_reg;
    logic [SLOT_W-1:0]         filter_count_reg;
    logic [SLOT_VEC_W-1:0]     slot_ids_reg;
    logic [SLOT_VEC_W-1:0]     slot_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            inv_scale_x_reg  <= INV_ONE;
            inv_scale_y_reg  <= INV_ONE;
            default_thr_reg  <= '0;
            filter_count_reg <= '0;
            slot_ids_reg     <= '0;
            slot_thr_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_OFFSET_X:        offset_x_reg     <= cfg_data[COORD_W-1:0];
                REG_OFFSET_Y:        offset_y_reg     <= cfg_data[COORD_W-1:0];
                REG_INV_SCALE_X:     inv_scale_x_reg  <= cfg_data[INV_W-1:0];
                REG_INV_SCALE_Y:     inv_scale_y_reg  <= cfg_data[INV_W-1:0];
                REG_DEFAULT_THR:     default_thr_reg  <= cfg_data[CONF_W-1:0];
                REG_FILTER_COUNT:    filter_count_reg <= cfg_data[SLOT_W-1:0];
                REG_SLOT_CLASS_IDS:  slot_ids_reg     <= cfg_data[SLOT_VEC_W-1:0];
                REG_SLOT_THRESHOLDS: slot_thr_reg     <= cfg_data[SLOT_VEC_W-1:0];
                default:             ;
            endcase
        end
    end

    // Unpack the input row
    logic signed [COORD_W-1:0] in_cx [4];
    logic signed [COORD_W-1:0] in_cy [4];
    logic [CONF_W-1:0]         in_conf;
    logic [CLASS_W-1:0]        in_cls;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            in_cx[i] = s_tdata[2*i*COORD_W +: COORD_W];
            in_cy[i] = s_tdata[(2*i+1)*COORD_W +: COORD_W];
        end
    end

    assign in_conf = s_tdata[8*COORD_W +: CONF_W];
    assign in_cls  = s_tdata[8*COORD_W+CONF_W +: CLASS_W];

    // Class filter and threshold check
    logic [SLOT_W-1:0]    n_eff;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_slot;
    logic [SLOT_ID_W-1:0] hit_thr;
    logic                 pass;
    meta_t                meta_in;

    assign n_eff = (filter_count_reg > SLOT_W'(NUM_SLOTS)) ? SLOT_W'(NUM_SLOTS)
                                                           : filter_count_reg;

    // Scan downward so the lowest matching slot wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = LABEL_GENERIC;
        hit_thr  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if ((SLOT_W'(i) < n_eff) && (slot_ids_reg[i*SLOT_ID_W +: SLOT_ID_W] == in_cls))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
                hit_thr  = slot_thr_reg[i*SLOT_ID_W +: SLOT_ID_W];
            end
        end
    end

    always_comb
    begin
        pass = (in_conf != '0) && (in_conf <= CONF_ONE);
        if (n_eff == '0)
        begin
            pass = pass && (in_conf >= default_thr_reg);
        end
        else
        begin
            pass = pass && hit && (in_conf >= CONF_W'(hit_thr));
        end
    end

    assign meta_in.score = in_conf;
    assign meta_in.cls   = in_cls;
    assign meta_in.slot  = (n_eff == '0) ? LABEL_GENERIC : hit_slot;

    // Pipeline flow control: a stage loads when empty or when it drains
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld_ready;
    logic ok5;
    stage_ce_t ce;

    assign rdy5 = !v5_reg || ld_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign ce.s1 = rdy1;
    assign ce.s2 = rdy2;
    assign ce.s3 = rdy3;
    assign ce.s4 = rdy4;
    assign ce.s5 = rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid && pass;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg && ok5;
            end
        end
    end

    // Row attributes travel beside the coordinates
    meta_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            m1_reg <= meta_in;
        end
        if (rdy2)
        begin
            m2_reg <= m1_reg;
        end
        if (rdy3)
        begin
            m3_reg <= m2_reg;
        end
        if (rdy4)
        begin
            m4_reg <= m3_reg;
        end
        if (rdy5)
        begin
            m5_reg <= m4_reg;
        end
    end

    // Coordinate unmapping, one unit per coordinate
    logic signed [COORD_W-1:0] map_cx [4];
    logic signed [COORD_W-1:0] map_cy [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_corner
        odfu_map u_map_x (
            .clk       (clk),
            .ce        (ce),
            .coord     (in_cx[g]),
            .offset    (offset_x_reg),
            .inv_scale (inv_scale_x_reg),
            .mapped    (map_cx[g])
        );
        odfu_map u_map_y (
            .clk       (clk),
            .ce        (ce),
            .coord     (in_cy[g]),
            .offset    (offset_y_reg),
            .inv_scale (inv_scale_y_reg),
            .mapped    (map_cy[g])
        );
    end

    // Axis-aligned bounds
    logic signed [COORD_W-1:0] b_cx [4];
    logic signed [COORD_W-1:0] b_cy [4];
    logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
    logic                      ok_x, ok_y;

    odfu_bounds u_bounds_x (
        .clk       (clk),
        .ce        (ce),
        .coord     (map_cx),
        .coord_out (b_cx),
        .lo        (min_x),
        .hi        (max_x),
        .extent_ok (ok_x)
    );

    odfu_bounds u_bounds_y (
        .clk       (clk),
        .ce        (ce),
        .coord     (map_cy),
        .coord_out (b_cy),
        .lo        (min_y),
        .hi        (max_y),
        .extent_ok (ok_y)
    );

    assign ok5 = ok_x && ok_y;

    // Assemble the finished row
    row_t row;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            row.cx[i] = b_cx[i];
            row.cy[i] = b_cy[i];
        end
        row.min_x = min_x;
        row.max_x = max_x;
        row.min_y = min_y;
        row.max_y = max_y;
        row.meta  = m5_reg;
    end

    odfu_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld_valid (v5_reg),
        .ld_ready (ld_ready),
        .row      (row),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: design/odfu_checker.sv
// Port-level checks on the output stream of the OBB detection filter, with bind.
`default_nettype none

module odfu_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                m_tlast,
    input  logic [odfu_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import odfu_pkg::*;

    localparam int BX_LO   = 4 * COORD_W;
    localparam int BY_LO   = 5 * COORD_W;
    localparam int META_LO = 6 * COORD_W;
    localparam int META_W  = CONF_W + CLASS_W + SLOT_W;

    // Hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // A first beat is always followed by the second beat of the same row
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second beat missing after first beat");

    // Score, class and slot agree across the two beats
    a_meta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tdata[META_LO +: META_W] == $past(m_tdata[META_LO +: META_W]))
        else $error("row attributes differ between beats");

    // Maximum bounds lie strictly above the minimum bounds
    a_extent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            ($signed(m_tdata[BX_LO +: COORD_W]) > $signed($past(m_tdata[BX_LO +: COORD_W])))
            && ($signed(m_tdata[BY_LO +: COORD_W])
                > $signed($past(m_tdata[BY_LO +: COORD_W]))))
        else $error("row sent without positive extent");

endmodule

bind obb_detection_filter_unmap odfu_checker u_odfu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/obb_detection_filter_unmap_test.sv
// Testbench for the oriented-box filter: random and directed rows, predicted results, scoreboard.
`timescale 1ns / 1ps

module obb_detection_filter_unmap_test;

    import odfu_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    // One output transfer, split into its fields
    typedef struct packed {
        logic               last;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] bnd_x;
        logic [COORD_W-1:0] bnd_y;
        logic [CONF_W-1:0]  score;
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } box_beat_t;

    // Register shadow, row filter and corner unmapping, plus the queue of
    // output transfers still owed by the block
    class box_scoreboard;
        logic signed [COORD_W-1:0] off_x;
        logic signed [COORD_W-1:0] off_y;
        logic [INV_W-1:0]          inv_x;
        logic [INV_W-1:0]          inv_y;
        logic [CONF_W-1:0]         dflt_thr;
        logic [SLOT_W-1:0]         filt_cnt;
        logic [SLOT_VEC_W-1:0]     slot_ids;
        logic [SLOT_VEC_W-1:0]     slot_thr;
        box_beat_t                 owed_beats[$];
        int                        errors;

        function new();
            off_x    = '0;
            off_y    = '0;
            inv_x    = INV_ONE;
            inv_y    = INV_ONE;
            dflt_thr = '0;
            filt_cnt = '0;
            slot_ids = '0;
            slot_thr = '0;
            errors   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_OFFSET_X:        off_x    = val[COORD_W-1:0];
                REG_OFFSET_Y:        off_y    = val[COORD_W-1:0];
                REG_INV_SCALE_X:     inv_x    = val[INV_W-1:0];
                REG_INV_SCALE_Y:     inv_y    = val[INV_W-1:0];
                REG_DEFAULT_THR:     dflt_thr = val[CONF_W-1:0];
                REG_FILTER_COUNT:    filt_cnt = val[SLOT_W-1:0];
                REG_SLOT_CLASS_IDS:  slot_ids = val;
                REG_SLOT_THRESHOLDS: slot_thr = val;
                default: ;
            endcase
        endfunction

        // (c - offset) * inv_scale, round half up, drop the 16 fraction bits, saturate
        function longint map_axis(logic signed [COORD_W-1:0] c,
                                  logic signed [COORD_W-1:0] off,
                                  logic [INV_W-1:0] inv);
            longint prod;
            longint q;
            prod = (longint'(c) - longint'(off)) * longint'({40'd0, inv});
            q = (prod + 64'sd32768) >>> 16;
            if (q > 64'sd524287)
                q = 64'sd524287;
            if (q < -64'sd524288)
                q = -64'sd524288;
            return q;
        endfunction

        function void note_row(logic [IN_TDATA_W-1:0] d);
            logic [CONF_W-1:0]  conf;
            logic [CLASS_W-1:0] cls;
            logic [CONF_W-1:0]  thr;
            logic [SLOT_W-1:0]  slot;
            longint             mx[4];
            longint             my[4];
            longint             lo_x, hi_x, lo_y, hi_y;
            int                 n;
            int                 i;
            int                 s;
            bit                 hit;
            box_beat_t          b;
            conf = d[8*COORD_W +: CONF_W];
            cls  = d[8*COORD_W+CONF_W +: CLASS_W];
            if (conf == '0 || conf > CONF_ONE)
                return;

            // Pick the threshold: first matching slot, or the default
            n    = (filt_cnt > SLOTS) ? SLOTS : int'(filt_cnt);
            slot = LABEL_GENERIC;
            hit  = 1'b0;
            s    = 0;
            if (n > 0) begin
                for (i = 0; i < n; i++) begin
                    if (!hit && slot_ids[SLOT_ID_W*i +: SLOT_ID_W] == cls) begin
                        hit  = 1'b1;
                        s    = i;
                        slot = SLOT_W'(i);
                    end
                end
                if (!hit)
                    return;
                thr = {1'b0, slot_thr[SLOT_ID_W*s +: SLOT_ID_W]};
            end else begin
                thr = dflt_thr;
            end
            if (conf < thr)
                return;

            // Unmap corners and form the axis-aligned bounds
            for (i = 0; i < 4; i++) begin
                mx[i] = map_axis(d[2*COORD_W*i +: COORD_W], off_x, inv_x);
                my[i] = map_axis(d[2*COORD_W*i+COORD_W +: COORD_W], off_y, inv_y);
            end
            lo_x = mx[0];
            hi_x = mx[0];
            lo_y = my[0];
            hi_y = my[0];
            for (i = 1; i < 4; i++) begin
                if (mx[i] < lo_x) lo_x = mx[i];
                if (mx[i] > hi_x) hi_x = mx[i];
                if (my[i] < lo_y) lo_y = my[i];
                if (my[i] > hi_y) hi_y = my[i];
            end
            if (hi_x <= lo_x || hi_y <= lo_y)
                return;

            b.score = conf;
            b.cls   = cls;
            b.slot  = slot;
            b.last  = 1'b0;
            b.ax    = COORD_W'(mx[0]);
            b.ay    = COORD_W'(my[0]);
            b.bx    = COORD_W'(mx[1]);
            b.by    = COORD_W'(my[1]);
            b.bnd_x = COORD_W'(lo_x);
            b.bnd_y = COORD_W'(lo_y);
            owed_beats = {owed_beats, b};
            b.last  = 1'b1;
            b.ax    = COORD_W'(mx[2]);
            b.ay    = COORD_W'(my[2]);
            b.bx    = COORD_W'(mx[3]);
            b.by    = COORD_W'(my[3]);
            b.bnd_x = COORD_W'(hi_x);
            b.bnd_y = COORD_W'(hi_y);
            owed_beats = {owed_beats, b};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("%0t error: %s", $realtime, msg);
        endtask

        task cmp_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_beat(box_beat_t got);
            box_beat_t want;
            if (owed_beats.size() == 0) begin
                report("output transfer with no row outstanding");
                return;
            end
            want = owed_beats.pop_front();
            cmp_field("tlast", got.last, want.last);
            cmp_field("corner_a_x", got.ax, want.ax);
            cmp_field("corner_a_y", got.ay, want.ay);
            cmp_field("corner_b_x", got.bx, want.bx);
            cmp_field("corner_b_y", got.by, want.by);
            cmp_field("bound_x", got.bnd_x, want.bnd_x);
            cmp_field("bound_y", got.bnd_y, want.bnd_y);
            cmp_field("score", got.score, want.score);
            cmp_field("class_out", got.cls, want.cls);
            cmp_field("label_slot", got.slot, want.slot);
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_data;

    box_scoreboard sb;
    bit            no_idle;
    bit            choke_req;

    obb_detection_filter_unmap #(
        .NUM_SLOTS (SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] make_row(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
        input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2,
        input logic [COORD_W-1:0] x3, input logic [COORD_W-1:0] y3,
        input logic [CONF_W-1:0] conf, input logic [CLASS_W-1:0] cls);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0*COORD_W +: COORD_W] = x0;
        d[1*COORD_W +: COORD_W] = y0;
        d[2*COORD_W +: COORD_W] = x1;
        d[3*COORD_W +: COORD_W] = y1;
        d[4*COORD_W +: COORD_W] = x2;
        d[5*COORD_W +: COORD_W] = y2;
        d[6*COORD_W +: COORD_W] = x3;
        d[7*COORD_W +: COORD_W] = y3;
        d[8*COORD_W +: CONF_W] = conf;
        d[8*COORD_W+CONF_W +: CLASS_W] = cls;
        return d;
    endfunction

    // Mostly boxes around a random center with a class the filter knows;
    // some rows carry bad confidence, some are raw random bits
    function automatic logic [IN_TDATA_W-1:0] rand_row();
        logic [COORD_W-1:0] cx, cy, w, h, k;
        logic [CONF_W-1:0]  conf;
        logic [CLASS_W-1:0] cls;
        int                 kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return make_row(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom), COORD_W'($urandom),
                            CONF_W'($urandom), CLASS_W'($urandom));
        cx = COORD_W'($urandom_range(0, 131072)) - COORD_W'(65536);
        cy = COORD_W'($urandom_range(0, 131072)) - COORD_W'(65536);
        w  = COORD_W'($urandom_range(1, 4000));
        h  = COORD_W'($urandom_range(1, 4000));
        k  = COORD_W'($urandom_range(0, 500));
        if (sb.filt_cnt != '0 && $urandom_range(0, 4) != 0)
            cls = sb.slot_ids[SLOT_ID_W*$urandom_range(0, SLOTS-1) +: SLOT_ID_W];
        else
            cls = CLASS_W'($urandom_range(0, 7));
        if (kind == 1)
            conf = $urandom_range(0, 1) ? '0 : CONF_W'($urandom_range(65537, 131071));
        else if ($urandom_range(0, 9) == 0)
            conf = CONF_ONE;
        else
            conf = CONF_W'($urandom_range(1, 65536));
        return make_row(cx - w, cy - h + k, cx + w - k, cy - h,
                        cx + w, cy + h - k, cx - w + k, cy + h, conf, cls);
    endfunction

    function automatic logic [COORD_W-1:0] rand_offset();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return COORD_W'($urandom_range(0, 8000)) - COORD_W'(4000);
        endcase
    endfunction

    function automatic logic [INV_W-1:0] rand_inv();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return INV_W'($urandom_range(1, 100));
            default: return INV_W'($urandom_range(16384, 262144));
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Offer one row, hold it until the transfer happens
    task automatic send_row(logic [IN_TDATA_W-1:0] d);
        int gap;
        gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_row(d);
    endtask

    // Stop offering, wait out owed results and any rejected rows in flight
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.owed_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic rand_config(bit extreme);
        logic [CFG_DATA_W-1:0] ids;
        logic [CFG_DATA_W-1:0] thrs;
        int                    i;
        ids  = '0;
        thrs = '0;
        for (i = 0; i < MAX_SLOTS; i++) begin
            ids[SLOT_ID_W*i +: SLOT_ID_W] = ($urandom_range(0, 5) == 0) ?
                SLOT_ID_W'($urandom) : SLOT_ID_W'($urandom_range(0, 7));
            thrs[SLOT_ID_W*i +: SLOT_ID_W] = ($urandom_range(0, 7) == 0) ?
                SLOT_ID_W'(65535) : SLOT_ID_W'($urandom_range(0, 40000));
        end
        write_reg(REG_OFFSET_X, CFG_DATA_W'(extreme ? COORD_MAX : rand_offset()));
        write_reg(REG_OFFSET_Y, CFG_DATA_W'(extreme ? COORD_MIN : rand_offset()));
        write_reg(REG_INV_SCALE_X, CFG_DATA_W'(extreme ? INV_W'(1) : rand_inv()));
        write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(extreme ? {INV_W{1'b1}} : rand_inv()));
        case ($urandom_range(0, 7))
            0:       write_reg(REG_DEFAULT_THR, CFG_DATA_W'($urandom_range(65537, 131071)));
            1:       write_reg(REG_DEFAULT_THR, CFG_DATA_W'(CONF_ONE));
            default: write_reg(REG_DEFAULT_THR, CFG_DATA_W'($urandom_range(0, 50000)));
        endcase
        write_reg(REG_FILTER_COUNT,
                  ($urandom_range(0, 2) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 7)));
        write_reg(REG_SLOT_CLASS_IDS, ids);
        write_reg(REG_SLOT_THRESHOLDS, thrs);
    endtask

    // Receiver: random stalls, or one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (choke_req) begin
                choke_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                hold_left = idle_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every output transfer against the oldest owed result
    always @(posedge clk) begin
        box_beat_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.last  = m_tlast;
            got.ax    = m_tdata[0*COORD_W +: COORD_W];
            got.ay    = m_tdata[1*COORD_W +: COORD_W];
            got.bx    = m_tdata[2*COORD_W +: COORD_W];
            got.by    = m_tdata[3*COORD_W +: COORD_W];
            got.bnd_x = m_tdata[4*COORD_W +: COORD_W];
            got.bnd_y = m_tdata[5*COORD_W +: COORD_W];
            got.score = m_tdata[6*COORD_W +: CONF_W];
            got.cls   = m_tdata[6*COORD_W+CONF_W +: CLASS_W];
            got.slot  = m_tdata[6*COORD_W+CONF_W+CLASS_W +: SLOT_W];
            sb.check_beat(got);
        end
    end

    initial begin
        #8_000_000;
        $display("obb_detection_filter_unmap_test NOT OK");
        $finish;
    end

    initial begin
        int ph;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        choke_req = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: confidence limits, coordinate extremes, flat boxes
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, '0, 16'd1));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, CONF_ONE, 16'hFFFF));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd65537, 16'd2));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'h1FFFF, 16'd3));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd1, 16'd0));
        send_row(make_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 17'd40000, 16'd5));
        send_row(make_row(-50, -50, -50, -50, -50, -50, -50, -50, 17'd40000, 16'd5));
        send_row(make_row(80, 0, 80, 30, 80, 60, 80, 90, 17'd40000, 16'd5));
        send_row(make_row(0, 80, 30, 80, 60, 80, 90, 80, 17'd40000, 16'd5));
        send_row(make_row(-400, -100, -300, -200, -200, -100, -300, 0, 17'd40000, 16'd6));
        drain();

        // Extreme offsets and scales: saturation on both ends
        write_reg(REG_OFFSET_X, CFG_DATA_W'(COORD_MIN));
        write_reg(REG_OFFSET_Y, CFG_DATA_W'(COORD_MAX));
        write_reg(REG_INV_SCALE_X, CFG_DATA_W'({INV_W{1'b1}}));
        write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(1));
        write_reg(REG_DEFAULT_THR, '0);
        write_reg(REG_FILTER_COUNT, '0);
        write_reg(REG_SLOT_CLASS_IDS, '0);
        write_reg(REG_SLOT_THRESHOLDS, '0);
        send_row(make_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 17'd40000, 16'd5));
        send_row(make_row(-400, -100, -300, -200, -200, -100, -300, 0, 17'd40000, 16'd6));
        drain();

        // Half scale: rounding ties go up; then a zero x scale flattens the box
        write_reg(REG_OFFSET_X, '0);
        write_reg(REG_OFFSET_Y, '0);
        write_reg(REG_INV_SCALE_X, CFG_DATA_W'(32768));
        write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(32768));
        send_row(make_row(-1, -1, 1, -1, 1, 1, -1, 1, 17'd40000, 16'd4));
        drain();
        write_reg(REG_INV_SCALE_X, '0);
        send_row(make_row(-1, -1, 1, -1, 1, 1, -1, 1, 17'd40000, 16'd4));
        drain();

        // Class filter: duplicate ids take the lowest slot, inactive slots miss
        write_reg(REG_INV_SCALE_X, CFG_DATA_W'(INV_ONE));
        write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(INV_ONE));
        write_reg(REG_FILTER_COUNT, CFG_DATA_W'(3));
        write_reg(REG_SLOT_CLASS_IDS, 64'hFFFF_0009_0007_0007);
        write_reg(REG_SLOT_THRESHOLDS, 64'h0005_FFFF_0000_0064);
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd100, 16'd7));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd99, 16'd7));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd65535, 16'd9));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd65534, 16'd9));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd60000, 16'hFFFF));
        drain();
        write_reg(REG_FILTER_COUNT, CFG_DATA_W'(7));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd60000, 16'hFFFF));
        drain();

        // Default threshold above one rejects all; exactly one passes only one
        write_reg(REG_FILTER_COUNT, '0);
        write_reg(REG_DEFAULT_THR, CFG_DATA_W'(65537));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, CONF_ONE, 16'd1));
        drain();
        write_reg(REG_DEFAULT_THR, CFG_DATA_W'(CONF_ONE));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, CONF_ONE, 16'd1));
        send_row(make_row(0, 0, 160, 0, 160, 160, 0, 160, 17'd65535, 16'd1));
        drain();

        // Random phases, each with fresh settings; one long receiver hold-off
        for (ph = 0; ph < 7; ph++) begin
            rand_config(ph == 0);
            no_idle = (ph == 2 || ph == 5);
            if (ph == 2)
                choke_req = 1'b1;
            repeat (180) send_row(rand_row());
            drain();
        end

        if (sb.errors == 0)
            $display("obb_detection_filter_unmap_test OK");
        else
            $display("obb_detection_filter_unmap_test NOT OK");
        $finish;
    end

endmodule

FILE: files.f
design/odfu_pkg.sv
design/odfu_map.sv
design/odfu_bounds.sv
design/odfu_out.sv
design/obb_detection_filter_unmap.sv
design/odfu_checker.sv
tb/obb_detection_filter_unmap_test.sv
